// File: rtl/pwc_pkg.sv
// Shared constants, types and the arctangent table of the phase winding counter.
`timescale 1ns / 1ps
`default_nettype none

package pwc_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int SCALE_BITS   = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ANGLE_W      = SCALE_BITS + 3;
  localparam int PHASE_W      = 16;
  localparam int CHARGE_W     = 12;
  localparam int THR_W        = 15;
  localparam int MAX_POINTS   = 1024;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [THR_W-1:0] THR_RESET = 15'd20861;

  // Half a turn in angle units, and the rounding that drops to phase units.
  localparam int HALF_TURN   = 1 << SCALE_BITS;
  localparam int ROUND_SHIFT = SCALE_BITS - (PHASE_W - 1);
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);
  localparam int PHASE_MAX   = (1 << (PHASE_W - 1)) - 1;
  localparam int PHASE_MIN   = -(1 << (PHASE_W - 1));

  localparam logic signed [ANGLE_W-1:0] HALF_TURN_C  = HALF_TURN[ANGLE_W-1:0];
  localparam logic signed [ANGLE_W-1:0] ROUND_BIAS_C = ROUND_BIAS[ANGLE_W-1:0];
  localparam logic signed [PHASE_W-1:0] PHASE_MAX_C  = PHASE_MAX[PHASE_W-1:0];
  localparam logic signed [PHASE_W-1:0] PHASE_MIN_C  = PHASE_MIN[PHASE_W-1:0];

  localparam int COUNT_HI = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;
  localparam int COUNT_LO = (MAX_POINTS < 2048) ? -MAX_POINTS : -2048;

  localparam logic signed [CHARGE_W-1:0] COUNT_HI_C = COUNT_HI[CHARGE_W-1:0];
  localparam logic signed [CHARGE_W-1:0] COUNT_LO_C = COUNT_LO[CHARGE_W-1:0];

  typedef struct packed {
    logic signed [PHASE_W-1:0] phase;
    logic                      last;
  } pwc_entry_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_ROTATE,
    FRONT_PUSH
  } front_state_e;

  typedef enum logic {
    BACK_RUN,
    BACK_CLOSE
  } back_state_e;

  // atan(2^-i) in units of pi/2^20.
  function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 23'sd262144;
      5'd1:    a = 23'sd154753;
      5'd2:    a = 23'sd81767;
      5'd3:    a = 23'sd41506;
      5'd4:    a = 23'sd20834;
      5'd5:    a = 23'sd10427;
      5'd6:    a = 23'sd5215;
      5'd7:    a = 23'sd2608;
      5'd8:    a = 23'sd1304;
      5'd9:    a = 23'sd652;
      5'd10:   a = 23'sd326;
      5'd11:   a = 23'sd163;
      5'd12:   a = 23'sd81;
      5'd13:   a = 23'sd41;
      5'd14:   a = 23'sd20;
      5'd15:   a = 23'sd10;
      5'd16:   a = 23'sd5;
      5'd17:   a = 23'sd3;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pwc_phase_front.sv
// Front part: accepts samples and finds each phase with an iterative CORDIC.
`timescale 1ns / 1ps
`default_nettype none

module pwc_phase_front #(
  parameter int SAMPLE_BITS = pwc_pkg::SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  input  wire logic                          last_sample_i,
  output      logic                          push_o,
  output      pwc_pkg::pwc_entry_t           push_entry_o,
  input  wire logic                          queue_full_i
);

  localparam int W = SAMPLE_BITS + pwc_pkg::SCALE_BITS + 2;

  pwc_pkg::front_state_e state_q, state_d;

  logic signed [W-1:0]                  x_q, x_d, y_q, y_d;
  logic signed [pwc_pkg::ANGLE_W-1:0]   z_q, z_d;
  logic [pwc_pkg::STEP_W-1:0]           step_q, step_d;
  logic                                 zero_q, zero_d;
  logic                                 last_q, last_d;

  logic signed [W-1:0]                  x_init, y_init;
  logic signed [pwc_pkg::ANGLE_W-1:0]   z_round;
  logic signed [pwc_pkg::ANGLE_W-1:0]   z_shift;
  logic signed [pwc_pkg::PHASE_W-1:0]   phase;
  logic                                 accept;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwc_pkg::FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    step_q <= step_d;
    zero_q <= zero_d;
    last_q <= last_d;
  end

  assign x_init = {{2{sample_real_i[SAMPLE_BITS-1]}}, sample_real_i,
                   {pwc_pkg::SCALE_BITS{1'b0}}};
  assign y_init = {{2{sample_imag_i[SAMPLE_BITS-1]}}, sample_imag_i,
                   {pwc_pkg::SCALE_BITS{1'b0}}};

  // Round the angle to phase units and saturate, so a half turn reads as the top code.
  assign z_round = z_q + pwc_pkg::ROUND_BIAS_C;
  assign z_shift = z_round >>> pwc_pkg::ROUND_SHIFT;

  always_comb begin
    if (zero_q) begin
      phase = '0;
    end else if (z_shift > pwc_pkg::PHASE_MAX) begin
      phase = pwc_pkg::PHASE_MAX_C;
    end else if (z_shift < pwc_pkg::PHASE_MIN) begin
      phase = pwc_pkg::PHASE_MIN_C;
    end else begin
      phase = z_shift[pwc_pkg::PHASE_W-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    step_d       = step_q;
    zero_d       = zero_q;
    last_d       = last_q;
    in_stall_o   = 1'b1;
    push_o       = 1'b0;
    push_entry_o = '{phase: phase, last: last_q};

    case (state_q)
      pwc_pkg::FRONT_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          zero_d = (sample_real_i == '0) && (sample_imag_i == '0);
          last_d = last_sample_i;
          step_d = '0;
          // A sample in the left half plane is turned by half a turn first.
          if (sample_real_i[SAMPLE_BITS-1]) begin
            x_d = -x_init;
            y_d = -y_init;
            z_d = sample_imag_i[SAMPLE_BITS-1] ? -pwc_pkg::HALF_TURN_C
                                               : pwc_pkg::HALF_TURN_C;
          end else begin
            x_d = x_init;
            y_d = y_init;
            z_d = '0;
          end
          state_d = pwc_pkg::FRONT_ROTATE;
        end
      end
      pwc_pkg::FRONT_ROTATE: begin
        if (!y_q[W-1]) begin
          x_d = x_q + (y_q >>> step_q);
          y_d = y_q - (x_q >>> step_q);
          z_d = z_q + pwc_pkg::atan_step(step_q);
        end else begin
          x_d = x_q - (y_q >>> step_q);
          y_d = y_q + (x_q >>> step_q);
          z_d = z_q - pwc_pkg::atan_step(step_q);
        end
        step_d = step_q + 1'b1;
        if (step_q == pwc_pkg::STEP_W'(pwc_pkg::CORDIC_STEPS - 1)) begin
          state_d = pwc_pkg::FRONT_PUSH;
        end
      end
      pwc_pkg::FRONT_PUSH: begin
        if (!queue_full_i) begin
          push_o  = 1'b1;
          state_d = pwc_pkg::FRONT_IDLE;
        end
      end
      default: begin
        state_d = pwc_pkg::FRONT_IDLE;
      end
    endcase
  end

  a_accept_starts_rotation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == pwc_pkg::FRONT_ROTATE && step_q == '0)
    else $error("accepted sample did not start the rotation");

endmodule

`default_nettype wire

// File: rtl/pwc_queue.sv
// Short queue of classified phases between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module pwc_queue #(
  parameter int DEPTH = pwc_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire pwc_pkg::pwc_entry_t push_entry_i,
  output      logic                full_o,
  input  wire logic                pop_i,
  output      pwc_pkg::pwc_entry_t head_o,
  output      logic                empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pwc_pkg::pwc_entry_t entry_q [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == CNT_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue underflow");

endmodule

`default_nettype wire

// File: rtl/pwc_count_back.sv
// Back part: counts phase wraps around the ring and holds the charge result.
`timescale 1ns / 1ps
`default_nettype none

module pwc_count_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 jump_threshold_we_i,
  input  wire logic [pwc_pkg::THR_W-1:0]            jump_threshold_i,
  input  wire logic                                 empty_i,
  input  wire pwc_pkg::pwc_entry_t                  head_i,
  output      logic                                 pop_o,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic signed [pwc_pkg::CHARGE_W-1:0]  charge_o
);

  pwc_pkg::back_state_e state_q, state_d;

  logic [pwc_pkg::THR_W-1:0]            thr_q;
  logic signed [pwc_pkg::PHASE_W-1:0]   prev_q, prev_d, first_q, first_d;
  logic signed [pwc_pkg::CHARGE_W-1:0]  count_q, count_d, charge_q, charge_d;
  logic                                 at_start_q, at_start_d;
  logic                                 out_valid_q, out_valid_d;
  logic                                 out_free;

  // One step of the wrap count: a large rise counts down, a large fall counts up, saturating at the count bounds.
  function automatic logic signed [pwc_pkg::CHARGE_W-1:0] count_step(
    input logic signed [pwc_pkg::CHARGE_W-1:0] c,
    input logic signed [pwc_pkg::PHASE_W-1:0]  from_ph,
    input logic signed [pwc_pkg::PHASE_W-1:0]  to_ph,
    input logic [pwc_pkg::THR_W-1:0]           thr
  );
    logic signed [pwc_pkg::PHASE_W+1:0]  diff;
    logic signed [pwc_pkg::PHASE_W+1:0]  ndiff;
    logic signed [pwc_pkg::PHASE_W+1:0]  thr_s;
    logic signed [pwc_pkg::CHARGE_W:0]   n;
    logic signed [pwc_pkg::CHARGE_W-1:0] r;
    diff  = $signed({{2{to_ph[pwc_pkg::PHASE_W-1]}}, to_ph})
          - $signed({{2{from_ph[pwc_pkg::PHASE_W-1]}}, from_ph});
    ndiff = -diff;
    thr_s = $signed({{(pwc_pkg::PHASE_W + 2 - pwc_pkg::THR_W){1'b0}}, thr});
    n     = {c[pwc_pkg::CHARGE_W-1], c};
    if (diff > thr_s) begin
      n = n - 1'b1;
    end
    if (ndiff > thr_s) begin
      n = n + 1'b1;
    end
    if (n > pwc_pkg::COUNT_HI) begin
      r = pwc_pkg::COUNT_HI_C;
    end else if (n < pwc_pkg::COUNT_LO) begin
      r = pwc_pkg::COUNT_LO_C;
    end else begin
      r = n[pwc_pkg::CHARGE_W-1:0];
    end
    return r;
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign charge_o    = charge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwc_pkg::BACK_RUN;
      thr_q       <= pwc_pkg::THR_RESET;
      prev_q      <= '0;
      first_q     <= '0;
      count_q     <= '0;
      at_start_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      first_q     <= first_d;
      count_q     <= count_d;
      at_start_q  <= at_start_d;
      out_valid_q <= out_valid_d;
      if (jump_threshold_we_i) begin
        thr_q <= jump_threshold_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    charge_q <= charge_d;
  end

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    first_d     = first_q;
    count_d     = count_q;
    at_start_d  = at_start_q;
    charge_d    = charge_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;

    case (state_q)
      pwc_pkg::BACK_RUN: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          prev_d = head_i.phase;
          if (at_start_q) begin
            first_d    = head_i.phase;
            count_d    = '0;
            at_start_d = 1'b0;
          end else begin
            count_d = count_step(count_q, prev_q, head_i.phase, thr_q);
          end
          if (head_i.last) begin
            state_d = pwc_pkg::BACK_CLOSE;
          end
        end
      end
      pwc_pkg::BACK_CLOSE: begin
        // Close the ring with the pair last to first, then re-arm.
        if (out_free) begin
          charge_d    = count_step(count_q, prev_q, first_q, thr_q);
          out_valid_d = 1'b1;
          count_d     = '0;
          at_start_d  = 1'b1;
          state_d     = pwc_pkg::BACK_RUN;
        end
      end
      default: begin
        state_d = pwc_pkg::BACK_RUN;
      end
    endcase
  end

  a_count_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pwc_pkg::COUNT_HI && count_q >= pwc_pkg::COUNT_LO)
    else $error("wrap count outside its bound");

  a_start_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_start_q |-> count_q == '0)
    else $error("new ring does not start from a zero count");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(charge_q))
    else $error("stalled charge result was lost");

endmodule

`default_nettype wire

// File: rtl/phase_winding_counter_unit.sv
// Top level of the phase winding counter: phase front, queue and counting back part.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    sample_real_i, sample_imag_i, last_sample_i
//   result    out        out_valid_o / out_stall_i  charge_o
//   config    in         jump_threshold_we_i        jump_threshold_i
//
// In the front a sample is loaded, turned by 18 CORDIC micro-rotations on one shared
// shift-add unit and its phase pushed into the two-entry queue; no new sample is taken before the push.
// The back part takes one phase per cycle while the queue holds any; a ring close loads the result.
// Reset clears all control state, arms a new ring and sets the threshold to 20861.
// A stalled result holds the back part only at a ring close; the front goes on until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module phase_winding_counter_unit #(
  parameter int SAMPLE_BITS = pwc_pkg::SAMPLE_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 jump_threshold_we_i,
  input  wire logic [pwc_pkg::THR_W-1:0]            jump_threshold_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_real_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_imag_i,
  input  wire logic                                 last_sample_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic signed [pwc_pkg::CHARGE_W-1:0]  charge_o
);

  logic                push;
  logic                pop;
  logic                queue_full;
  logic                queue_empty;
  pwc_pkg::pwc_entry_t push_entry;
  pwc_pkg::pwc_entry_t head_entry;

  pwc_phase_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_real_i(sample_real_i),
    .sample_imag_i(sample_imag_i),
    .last_sample_i(last_sample_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .queue_full_i (queue_full)
  );

  pwc_queue #(
    .DEPTH(pwc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_o      (head_entry),
    .empty_o     (queue_empty)
  );

  pwc_count_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .jump_threshold_we_i(jump_threshold_we_i),
    .jump_threshold_i   (jump_threshold_i),
    .empty_i            (queue_empty),
    .head_i             (head_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .charge_o           (charge_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for the phase winding counter: ring stimulus, charge prediction and checking.
`timescale 1ns / 1ps

module tb_top;

  localparam int ANGLE_FRAC   = 20;
  localparam int CORDIC_ITERS = 18;
  localparam int ROUND_DROP   = 5;
  localparam int COUNT_MAX    = 1024;
  localparam int COUNT_MIN    = -1024;
  localparam int QUIET_CYCLES = 64;
  localparam int CALM_TAIL    = 120;
  localparam int LONG_TURNS   = 40;
  localparam int BLOCK_ITEMS  = 65;
  localparam int MAX_REPORTS  = 100;

  typedef enum logic [1:0] {
    STEP_SAMPLE,
    STEP_THRESHOLD,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e                      kind;
    logic signed [15:0]              re;
    logic signed [15:0]              im;
    logic                            last;
    logic [pwc_pkg::THR_W-1:0]       thr;
  } ring_step_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        jump_threshold_we_i = 1'b0;
  logic [pwc_pkg::THR_W-1:0]   jump_threshold_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [pwc_pkg::SAMPLE_BITS-1:0] sample_real_i = '0;
  logic signed [pwc_pkg::SAMPLE_BITS-1:0] sample_imag_i = '0;
  logic                        last_sample_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [pwc_pkg::CHARGE_W-1:0] charge_o;

  ring_step_t                  ring_steps[$];
  logic signed [pwc_pkg::CHARGE_W-1:0] charge_q[$];
  int                          mismatch_count = 0;

  // Shadow state of the winding counter.
  int winding_threshold = 20861;
  int ring_prev = 0;
  int ring_first = 0;
  int ring_count = 0;
  bit ring_fresh = 1'b1;

  // Driver and monitor bookkeeping.
  int         gap_left = 0;
  int         quiet = 0;
  int         stall_left = 0;
  bit         calm;
  ring_step_t head;
  logic       hold;
  logic       next_valid;
  logic       thr_we;
  logic signed [pwc_pkg::CHARGE_W-1:0] want;

  phase_winding_counter_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .jump_threshold_we_i (jump_threshold_we_i),
    .jump_threshold_i    (jump_threshold_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_real_i       (sample_real_i),
    .sample_imag_i       (sample_imag_i),
    .last_sample_i       (last_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .charge_o            (charge_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_500_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Charge prediction
  // ---------------------------------------------------------------------------

  function automatic longint arctan_unit(input int idx);
    case (idx)
      0:  return 262144;
      1:  return 154753;
      2:  return 81767;
      3:  return 41506;
      4:  return 20834;
      5:  return 10427;
      6:  return 5215;
      7:  return 2608;
      8:  return 1304;
      9:  return 652;
      10: return 326;
      11: return 163;
      12: return 81;
      13: return 41;
      14: return 20;
      15: return 10;
      16: return 5;
      default: return 3;
    endcase
  endfunction

  // Vectoring CORDIC; the angle is held in units of pi/2^20 and rounded to pi/2^15.
  function automatic logic signed [15:0] cordic_phase(input logic signed [15:0] re,
                                                      input logic signed [15:0] im);
    longint x, y, z, dx, dy, q;
    int     i;
    if (re == 0 && im == 0) return '0;
    x = longint'(re) <<< ANGLE_FRAC;
    y = longint'(im) <<< ANGLE_FRAC;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? (64'sd1 <<< ANGLE_FRAC) : -(64'sd1 <<< ANGLE_FRAC);
      x = -x;
      y = -y;
    end
    for (i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_unit(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_unit(i);
      end
    end
    q = (z + (64'sd1 <<< (ROUND_DROP - 1))) >>> ROUND_DROP;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void tally_pair(input int from_ph, input int to_ph);
    int diff, c;
    diff = to_ph - from_ph;
    c = ring_count;
    if (diff > winding_threshold) c = c - 1;
    if (-diff > winding_threshold) c = c + 1;
    if (c > COUNT_MAX) c = COUNT_MAX;
    if (c < COUNT_MIN) c = COUNT_MIN;
    ring_count = c;
  endfunction

  function automatic void advance_ring(input logic signed [15:0] re,
                                       input logic signed [15:0] im, input logic last);
    int ph;
    ph = cordic_phase(re, im);
    if (ring_fresh) begin
      ring_first = ph;
      ring_count = 0;
      ring_fresh = 1'b0;
    end else begin
      tally_pair(ring_prev, ph);
    end
    ring_prev = ph;
    if (last) begin
      // The last sample is also compared with the first to close the ring.
      tally_pair(ph, ring_first);
      charge_q.push_back(ring_count[pwc_pkg::CHARGE_W-1:0]);
      ring_count = 0;
      ring_fresh = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_sample(input int re, input int im, input bit last);
    ring_step_t s;
    s.kind = STEP_SAMPLE;
    s.re   = re[15:0];
    s.im   = im[15:0];
    s.last = last;
    s.thr  = '0;
    ring_steps.push_back(s);
  endtask

  task automatic add_threshold(input int value);
    ring_step_t s;
    s.kind = STEP_THRESHOLD;
    s.re   = '0;
    s.im   = '0;
    s.last = 1'b0;
    s.thr  = value[pwc_pkg::THR_W-1:0];
    ring_steps.push_back(s);
  endtask

  task automatic add_drain();
    ring_step_t s;
    s.kind = STEP_DRAIN;
    s.re   = '0;
    s.im   = '0;
    s.last = 1'b0;
    s.thr  = '0;
    ring_steps.push_back(s);
  endtask

  // Cosine of k * 22.5 degrees at amplitude 30000.
  function automatic int rim_cos(input int k);
    case (k & 15)
      0:  return 30000;
      1:  return 27716;
      2:  return 21213;
      3:  return 11481;
      4:  return 0;
      5:  return -11481;
      6:  return -21213;
      7:  return -27716;
      8:  return -30000;
      9:  return -27716;
      10: return -21213;
      11: return -11481;
      12: return 0;
      13: return 11481;
      14: return 21213;
      default: return 27716;
    endcase
  endfunction

  function automatic int pick_field();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // A ring that walks around the circle in random steps, so windings build up.
  task automatic add_walk_ring(input int len);
    int k, r, i;
    k = $urandom_range(0, 15);
    r = $urandom_range(1, 256);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        add_sample(0, 0, i == len - 1);
      end else begin
        add_sample(rim_cos(k) * r / 256, rim_cos(k + 12) * r / 256, i == len - 1);
      end
      k = k + int'($urandom_range(0, 14)) - 7;
      if ($urandom_range(0, 7) == 0) r = $urandom_range(1, 256);
    end
  endtask

  task automatic add_noise_ring(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      add_sample(pick_field(), pick_field(), i == len - 1);
    end
  endtask

  task automatic build_stimulus();
    int i, made, len, blk, thr;
    // Directed rings at the reset threshold.
    add_sample(0, 0, 1'b1);
    add_sample(32767, -32768, 1'b1);
    add_sample(32767, 0, 1'b0);
    add_sample(0, 32767, 1'b0);
    add_sample(-32768, 0, 1'b0);
    add_sample(-32768, -1, 1'b0);
    add_sample(0, -32768, 1'b0);
    add_sample(-32768, -32768, 1'b0);
    add_sample(32767, 32767, 1'b0);
    add_sample(-1, 0, 1'b0);
    add_sample(-1, -1, 1'b0);
    add_sample(1, -1, 1'b0);
    add_sample(0, 0, 1'b0);
    add_sample(-32768, 32767, 1'b0);
    add_sample(32767, -32768, 1'b1);
    add_sample(2, 0, 1'b0);
    add_sample(-1, 2, 1'b0);
    add_sample(-1, -2, 1'b1);
    for (i = 0; i < 8; i++) begin
      add_sample(rim_cos(-4 * i), rim_cos(-4 * i + 12), i == 7);
    end

    // Long rings that build up a large count, one each way.
    add_threshold(30000);
    for (i = 0; i < 3 * LONG_TURNS; i++) begin
      case (i % 3)
        0:       add_sample(20000, 0, 1'b0);
        1:       add_sample(-10000, 17321, 1'b0);
        default: add_sample(-10000, -17321, i == 3 * LONG_TURNS - 1);
      endcase
    end
    for (i = 0; i < 3 * LONG_TURNS; i++) begin
      case (i % 3)
        0:       add_sample(20000, 0, 1'b0);
        1:       add_sample(-10000, -17321, 1'b0);
        default: add_sample(-10000, 17321, i == 3 * LONG_TURNS - 1);
      endcase
    end

    // Random rings under a range of thresholds, the extremes first.
    for (blk = 0; blk < 8; blk++) begin
      case (blk)
        0:       thr = 0;
        1:       thr = 32767;
        2:       thr = 20861;
        3:       thr = 16384;
        default: thr = $urandom_range(0, 32767);
      endcase
      add_threshold(thr);
      made = 0;
      while (made < BLOCK_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            len = $urandom_range(2, 16);
            add_walk_ring(len);
          end
          6, 7: begin
            len = $urandom_range(1, 8);
            add_noise_ring(len);
          end
          default: begin
            len = 1;
            add_noise_ring(len);
          end
        endcase
        made = made + len;
      end
      if (blk == 3) add_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents samples and register writes from the pending queue.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i          <= 1'b0;
      jump_threshold_we_i <= 1'b0;
      gap_left            <= 0;
      quiet               <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_ring(sample_real_i, sample_imag_i, last_sample_i);
      end
      calm       = ring_steps.size() < CALM_TAIL;
      hold       = in_valid_i && in_stall_o;
      next_valid = hold;
      thr_we     = 1'b0;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (ring_steps.size() != 0) begin
          head = ring_steps[0];
          case (head.kind)
            STEP_SAMPLE: begin
              if (!calm && $urandom_range(0, 5) == 0) begin
                gap_left <= $urandom_range(0, 11);
              end else begin
                sample_real_i <= head.re;
                sample_imag_i <= head.im;
                last_sample_i <= head.last;
                next_valid = 1'b1;
                void'(ring_steps.pop_front());
              end
            end
            STEP_THRESHOLD: begin
              // Written only once the block has had time to finish every sample.
              if (quiet >= QUIET_CYCLES && charge_q.size() == 0) begin
                thr_we = 1'b1;
                jump_threshold_i <= head.thr;
                winding_threshold = head.thr;
                void'(ring_steps.pop_front());
              end
            end
            default: begin
              if (quiet >= QUIET_CYCLES && charge_q.size() == 0) begin
                void'(ring_steps.pop_front());
              end
            end
          endcase
        end
      end
      in_valid_i          <= next_valid;
      jump_threshold_we_i <= thr_we;
      if (in_valid_i || charge_q.size() != 0) begin
        quiet <= 0;
      end else if (quiet < QUIET_CYCLES) begin
        quiet <= quiet + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each charge transaction and stalls the result channel.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (charge_q.size() == 0) begin
          report_mismatch($sformatf("charge %0d with no ring pending", charge_o));
        end else begin
          want = charge_q.pop_front();
          if (charge_o !== want) begin
            report_mismatch($sformatf("charge %0d, predicted %0d", charge_o, want));
          end
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (ring_steps.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 11);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    build_stimulus();
    while (ring_steps.size() != 0 || in_valid_i || charge_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
